@@ hdl/dlib_pkg.sv @@
package dlib_pkg;

    localparam int C_LANES = 64;

    localparam logic [31:0] C_ZERO_SEED    = 32'h0000_0963;
    localparam logic [31:0] C_GOLDEN       = 32'h9E37_79B9;
    localparam logic [31:0] C_INJ_MUL      = 32'd1103515245;
    localparam logic [31:0] C_INJ_ADD      = 32'd12345;
    localparam logic [31:0] C_STEP_MUL     = 32'd1664525;
    localparam logic [31:0] C_STEP_ADD     = 32'd1013904223;
    localparam logic [31:0] C_CHK_MUL      = 32'hA5A5_A5A5;
    localparam logic [31:0] C_CHK_LANE_MUL = 32'd17;
    localparam int          C_PHI_SIGMA    = 91830;
    localparam int          C_ALPHA        = 16384;
    // Drive gain in Q16, about 0.35.
    localparam int          C_GAIN         = (C_PHI_SIGMA * C_ALPHA) >> 16;
    localparam logic [16:0] C_LEVEL_ONE    = 17'd65536;

    typedef enum logic [1:0] {
        OP_INIT   = 2'd0,
        OP_INJECT = 2'd1,
        OP_STEP   = 2'd2,
        OP_READ   = 2'd3
    } t_op;

    typedef struct packed {
        t_op         operation;
        logic [31:0] init_seed;
        logic [31:0] salt;
    } t_cmd;

    typedef struct packed {
        logic [31:0] checksum;
        logic [31:0] step_total;
    } t_res;

    // One lane of the bank as it sits in the lane memory.
    typedef struct packed {
        logic [16:0] prev;
        logic [16:0] level;
        logic [15:0] drv;
    } t_row;

    typedef enum logic [2:0] {
        ST_BOOT,
        ST_IDLE,
        ST_WALK,
        ST_DRAIN,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic start;
        logic boot;
        logic issue;
        logic load_result;
    } t_dp_ctl;

    typedef struct packed {
        logic last_lane;
        logic pipe_busy;
    } t_dp_sts;

endpackage

@@ hdl/dlib_if.sv @@
interface dlib_cmd_if;
    import dlib_pkg::*;

    logic valid;
    logic ready;
    t_cmd payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

interface dlib_res_if;
    import dlib_pkg::*;

    logic valid;
    logic ready;
    t_res payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

@@ hdl/dithered_leaky_integrator_bank.sv @@
// Bank of LANES leaky integrators in Q16 with dithered drives.
// Commands come in on i_cmd (operation, init_seed, salt); each command
// returns exactly one item on o_res (checksum, step_total). Operation codes
// are init, inject, step and read; read only recomputes the checksum.
// Every command walks the lane memory once, one lane per cycle, with the
// seed chain carried from lane to lane, and its result is loaded into the
// result register once the lane pipeline has drained. Commands do not
// overlap: a new command is taken once the previous walk has finished, even
// while its result still waits. If the receiver stalls, the finished walk of
// the next command holds in place until the output register frees; no result
// is dropped. After reset the block runs an init pass with seed zero over
// all lanes, during which i_cmd.ready is low and no result is sent.
module dithered_leaky_integrator_bank #(
    parameter int LANES = dlib_pkg::C_LANES
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    dlib_cmd_if.sink          i_cmd,
    dlib_res_if.source        o_res
);
    import dlib_pkg::*;

    t_dp_ctl dp_ctl;
    t_dp_sts dp_sts;
    logic    cmd_ready;
    logic    res_valid;
    t_res    res;

    dlib_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (i_cmd.valid),
        .o_cmd_ready (cmd_ready),
        .o_res_valid (res_valid),
        .i_res_ready (o_res.ready),
        .i_sts       (dp_sts),
        .o_ctl       (dp_ctl)
    );

    dlib_datapath #(
        .LANES (LANES)
    ) u_datapath (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (dp_ctl),
        .o_sts   (dp_sts),
        .i_cmd   (i_cmd.payload),
        .o_res   (res)
    );

    assign i_cmd.ready   = cmd_ready;
    assign o_res.valid   = res_valid;
    assign o_res.payload = res;

endmodule

@@ hdl/dlib_ctrl.sv @@
module dlib_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cmd_valid,
    output logic              o_cmd_ready,
    output logic              o_res_valid,
    input  logic              i_res_ready,
    input  dlib_pkg::t_dp_sts i_sts,
    output dlib_pkg::t_dp_ctl o_ctl
);
    import dlib_pkg::*;

    t_state r_state;
    t_state n_state;
    logic   r_boot;
    logic   n_boot;
    logic   r_res_valid;
    logic   n_res_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_BOOT;
            r_boot      <= 1'b1;
            r_res_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_boot      <= n_boot;
            r_res_valid <= n_res_valid;
        end
    end

    always_comb begin
        n_state = r_state;
        n_boot  = r_boot;
        case (r_state)
            ST_BOOT: begin
                n_state = ST_WALK;
            end
            ST_IDLE: begin
                if (i_cmd_valid) begin
                    n_state = ST_WALK;
                end
            end
            ST_WALK: begin
                if (i_sts.last_lane) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (!i_sts.pipe_busy) begin
                    // The pass after reset leaves no item to answer.
                    n_boot  = 1'b0;
                    n_state = r_boot ? ST_IDLE : ST_DONE;
                end
            end
            ST_DONE: begin
                if (!r_res_valid || i_res_ready) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        o_cmd_ready       = 1'b0;
        o_ctl             = '0;
        case (r_state)
            ST_BOOT: begin
                o_ctl.start = 1'b1;
                o_ctl.boot  = 1'b1;
            end
            ST_IDLE: begin
                o_cmd_ready = 1'b1;
                o_ctl.start = i_cmd_valid;
            end
            ST_WALK: begin
                o_ctl.issue = 1'b1;
            end
            ST_DONE: begin
                o_ctl.load_result = !r_res_valid || i_res_ready;
            end
            default: begin
                o_ctl = '0;
            end
        endcase
        if (o_ctl.load_result) begin
            n_res_valid = 1'b1;
        end else if (i_res_ready) begin
            n_res_valid = 1'b0;
        end else begin
            n_res_valid = r_res_valid;
        end
    end

    assign o_res_valid = r_res_valid;

    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ctl.load_result |-> (!r_res_valid || i_res_ready))
        else $error("result loaded over an item not yet taken");

    a_no_accept_boot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_boot |-> !(o_cmd_ready && i_cmd_valid))
        else $error("item accepted during the reset pass");

    a_walk_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_WALK && i_sts.last_lane) |=> (r_state == ST_DRAIN))
        else $error("lane walk did not end after the last lane");

endmodule

@@ hdl/dlib_datapath.sv @@
module dlib_datapath #(
    parameter int LANES = dlib_pkg::C_LANES
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  dlib_pkg::t_dp_ctl i_ctl,
    output dlib_pkg::t_dp_sts o_sts,
    input  dlib_pkg::t_cmd    i_cmd,
    output dlib_pkg::t_res    o_res
);
    import dlib_pkg::*;

    localparam int LW = (LANES > 1) ? $clog2(LANES) : 1;
    localparam int RW = LW + 1;
    localparam int DQ = 65536 / LANES;
    localparam int DR = 65536 % LANES;

    t_row mem [LANES];

    t_op         r_op;
    logic [31:0] r_seed;
    logic [31:0] r_count;
    logic [LW-1:0] r_lane;
    logic [31:0] r_kgold;
    logic [15:0] r_drv_q;
    logic [RW-1:0] r_drv_r;
    logic [31:0] r_chk;

    logic          r_b_valid;
    logic [LW-1:0] r_b_lane;
    logic [11:0]   r_b_jit;
    logic [15:0]   r_b_drv;
    t_row          r_q;

    logic          r_c_valid;
    logic [LW-1:0] r_c_lane;
    logic [16:0]   r_c_level;

    t_res r_res;

    logic [31:0]   inj_next;
    logic [31:0]   step_next;
    logic [RW-1:0] rem_sum;
    logic          rem_wrap;
    logic [15:0]   dyn;
    logic [30:0]   prod;
    logic [18:0]   prev3;
    logic [17:0]   v_sum;
    t_row          new_row;
    logic [31:0]   chk_mix;

    assign inj_next  = r_seed * C_INJ_MUL + C_INJ_ADD;
    assign step_next = r_seed * C_STEP_MUL + C_STEP_ADD;

    // Lane drive after init is floor(k * 65536 / LANES), kept as quotient and remainder.
    assign rem_sum  = r_drv_r + RW'(DR);
    assign rem_wrap = (rem_sum >= RW'(LANES));

    always_ff @(posedge i_clk) begin
        if (i_ctl.start) begin
            r_lane  <= '0;
            r_kgold <= '0;
            r_drv_q <= '0;
            r_drv_r <= '0;
            if (i_ctl.boot) begin
                r_op    <= OP_INIT;
                r_seed  <= C_ZERO_SEED;
                r_count <= '0;
            end else begin
                r_op <= i_cmd.operation;
                case (i_cmd.operation)
                    OP_INIT: begin
                        r_seed  <= (i_cmd.init_seed == '0) ? C_ZERO_SEED : i_cmd.init_seed;
                        r_count <= '0;
                    end
                    OP_INJECT: begin
                        r_seed <= r_seed ^ (i_cmd.salt * C_GOLDEN);
                    end
                    OP_STEP: begin
                        r_count <= r_count + 32'd1;
                    end
                    default: begin
                        r_seed <= r_seed;
                    end
                endcase
            end
        end else if (i_ctl.issue) begin
            r_lane  <= r_lane + LW'(1);
            r_kgold <= r_kgold + C_GOLDEN;
            if (rem_wrap) begin
                r_drv_r <= rem_sum - RW'(LANES);
                r_drv_q <= r_drv_q + 16'(DQ) + 16'd1;
            end else begin
                r_drv_r <= rem_sum;
                r_drv_q <= r_drv_q + 16'(DQ);
            end
            case (r_op)
                OP_INJECT: r_seed <= inj_next;
                OP_STEP:   r_seed <= step_next;
                default:   r_seed <= r_seed;
            endcase
        end
    end

    // Issue stage: read the lane and carry along what the seed chain gives it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else begin
            r_b_valid <= i_ctl.issue;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.issue) begin
            r_q      <= mem[r_lane];
            r_b_lane <= r_lane;
            r_b_jit  <= r_seed[11:0] ^ r_kgold[11:0];
            r_b_drv  <= (r_op == OP_INIT) ? r_drv_q : inj_next[15:0];
        end
    end

    // Update stage: new lane contents, written back to the same lane.
    assign dyn   = r_q.drv ^ {4'b0, r_b_jit};
    assign prod  = 31'(dyn) * 31'(C_GAIN);
    assign prev3 = {2'b0, r_q.prev} + {1'b0, r_q.prev, 1'b0};
    assign v_sum = 18'(prev3[18:2]) + 18'(prod[30:16]);

    always_comb begin
        case (r_op)
            OP_INIT: begin
                new_row.prev  = C_LEVEL_ONE;
                new_row.level = '0;
                new_row.drv   = r_b_drv;
            end
            OP_INJECT: begin
                new_row.prev  = r_q.prev;
                new_row.level = r_q.level;
                new_row.drv   = r_b_drv;
            end
            OP_STEP: begin
                new_row.prev  = v_sum[16:0];
                new_row.level = v_sum[16:0];
                new_row.drv   = r_q.drv;
            end
            default: begin
                new_row = r_q;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (r_b_valid) begin
            mem[r_b_lane] <= new_row;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_valid <= 1'b0;
        end else begin
            r_c_valid <= r_b_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_b_valid) begin
            r_c_level <= new_row.level;
            r_c_lane  <= r_b_lane;
        end
    end

    // Checksum stage. The seed value is set when lane zero is issued, before its level
    // has passed the issue and update stage registers to reach this stage.
    assign chk_mix = r_chk ^ (32'(r_c_level) + 32'(r_c_lane) * C_CHK_LANE_MUL);

    always_ff @(posedge i_clk) begin
        if (i_ctl.issue && r_lane == '0) begin
            r_chk <= r_count * C_CHK_MUL;
        end else if (r_c_valid) begin
            r_chk <= {chk_mix[28:0], chk_mix[31:29]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load_result) begin
            r_res.checksum   <= r_chk;
            r_res.step_total <= r_count;
        end
    end

    assign o_sts.last_lane = (r_lane == LW'(LANES - 1));
    assign o_sts.pipe_busy = r_b_valid || r_c_valid;
    assign o_res           = r_res;

    a_chk_base_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_ctl.issue && r_lane == '0) |-> (!r_b_valid && !r_c_valid))
        else $error("checksum base set while lanes are still in flight");

    a_no_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctl.start |-> !(r_b_valid || r_c_valid))
        else $error("new item started before the lane pipeline drained");

    a_result_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctl.load_result |-> !(r_b_valid || r_c_valid || i_ctl.issue))
        else $error("result loaded before the checksum was complete");

endmodule

@@ tb/sv/tb_top.sv @@
module tb_top;
    import dlib_pkg::*;

    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int RANDOM_ITEMS = 1850;
    localparam int TAIL_ITEMS = 250;

    // Holds a copy of the integrator bank and the results it still owes.
    class lane_bank_checker;
        localparam int DECAY_Q16 = 49152;

        bit [31:0] seed_now;
        bit [31:0] step_tally;
        bit [16:0] prev_lvl [C_LANES];
        bit [15:0] drive [C_LANES];
        bit [16:0] out_lvl [C_LANES];
        t_res      results_due [$];
        int        mismatch_count;

        function new();
            mismatch_count = 0;
            restart(32'd0);
        endfunction

        function void restart(bit [31:0] seed_in);
            seed_now = (seed_in == 32'd0) ? C_ZERO_SEED : seed_in;
            step_tally = 32'd0;
            for (int k = 0; k < C_LANES; k++) begin
                prev_lvl[k] = C_LEVEL_ONE;
                drive[k] = 16'((k << 16) / C_LANES);
                out_lvl[k] = 17'd0;
            end
        endfunction

        function void inject(bit [31:0] salt);
            bit [31:0] s;
            s = seed_now ^ (salt * C_GOLDEN);
            for (int k = 0; k < C_LANES; k++) begin
                s = s * C_INJ_MUL + C_INJ_ADD;
                drive[k] = s[15:0];
            end
            seed_now = s;
        endfunction

        function void advance();
            bit [31:0] s;
            bit [31:0] jit;
            bit [15:0] dyn;
            bit [63:0] blend;
            s = seed_now;
            for (int k = 0; k < C_LANES; k++) begin
                jit = s ^ (32'(k) * C_GOLDEN);
                // Only the low 12 bits of the chain dither the drive.
                dyn = drive[k] ^ {4'd0, jit[11:0]};
                blend = ((64'(prev_lvl[k]) * 64'(DECAY_Q16)) >> 16)
                      + ((64'(dyn) * 64'(C_GAIN)) >> 16);
                out_lvl[k] = blend[16:0];
                prev_lvl[k] = blend[16:0];
                s = s * C_STEP_MUL + C_STEP_ADD;
            end
            seed_now = s;
            step_tally = step_tally + 32'd1;
        endfunction

        function bit [31:0] checksum();
            bit [31:0] c;
            c = step_tally * C_CHK_MUL;
            for (int k = 0; k < C_LANES; k++) begin
                c = c ^ (32'(out_lvl[k]) + 32'(k) * C_CHK_LANE_MUL);
                c = {c[28:0], c[31:29]};
            end
            return c;
        endfunction

        function void note_command(t_cmd cmd);
            t_res want;
            case (cmd.operation)
                OP_INIT: begin
                    restart(cmd.init_seed);
                end
                OP_INJECT: begin
                    inject(cmd.salt);
                end
                OP_STEP: begin
                    advance();
                end
                default: begin
                end
            endcase
            want.checksum = checksum();
            want.step_total = step_tally;
            results_due.push_back(want);
        endfunction

        task report_mismatch(string msg);
            if (mismatch_count < 40) begin
                $display("mismatch: %s", msg);
            end
            mismatch_count++;
        endtask

        task check_result(t_res got);
            t_res want;
            if (results_due.size() == 0) begin
                report_mismatch($sformatf("result %h/%0d with nothing pending",
                                          got.checksum, got.step_total));
            end else begin
                want = results_due.pop_front();
                if (got.checksum !== want.checksum) begin
                    report_mismatch($sformatf("checksum got %h want %h",
                                              got.checksum, want.checksum));
                end
                if (got.step_total !== want.step_total) begin
                    report_mismatch($sformatf("step_total got %0d want %0d",
                                              got.step_total, want.step_total));
                end
            end
        endtask

        function int pending();
            return results_due.size();
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    bit quiet_tail = 1'b0;
    int stall_left = 0;
    int cycle_count = 0;
    lane_bank_checker bank = new();

    dlib_cmd_if cmd_if ();
    dlib_res_if res_if ();

    dithered_leaky_integrator_bank dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_if),
        .o_res   (res_if)
    );

    always #1 i_clk = ~i_clk;

    initial begin
        cmd_if.valid = 1'b0;
        cmd_if.payload = '0;
        res_if.ready = 1'b0;
    end

    // Result side: check what was taken at this edge, then pick the next ready.
    always @(posedge i_clk) begin
        if (i_rst_n && res_if.valid && res_if.ready) begin
            bank.check_result(res_if.payload);
        end
        if (stall_left > 0) begin
            stall_left--;
            res_if.ready <= 1'b0;
        end else if (!quiet_tail && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(0, 2);
            res_if.ready <= 1'b0;
        end else begin
            res_if.ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("tb_top: errors");
            $finish;
        end
    end

    function automatic t_cmd make_cmd(t_op op, logic [31:0] seed, logic [31:0] salt);
        t_cmd cmd;
        cmd.operation = op;
        cmd.init_seed = seed;
        cmd.salt = salt;
        return cmd;
    endfunction

    task automatic sender_gap(int cycles);
        cmd_if.valid <= 1'b0;
        repeat (cycles) @(posedge i_clk);
    endtask

    task automatic send_cmd(t_cmd cmd);
        if (!quiet_tail && $urandom_range(0, 3) == 0) begin
            sender_gap($urandom_range(1, 3));
        end
        cmd_if.valid <= 1'b1;
        cmd_if.payload <= cmd;
        @(posedge i_clk);
        while (!cmd_if.ready) @(posedge i_clk);
        bank.note_command(cmd);
    endtask

    // Holds the sender off until the bank has answered every item so far.
    task automatic drain_results();
        cmd_if.valid <= 1'b0;
        do @(posedge i_clk); while (bank.pending() != 0);
    endtask

    initial begin
        t_cmd cmd;
        int pick;

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: state after reset, zero and all-ones seeds and salts,
        // read-only commands between steps.
        send_cmd(make_cmd(OP_READ, 32'd0, 32'd0));
        send_cmd(make_cmd(OP_STEP, 32'd0, 32'd0));
        send_cmd(make_cmd(OP_STEP, 32'd0, 32'd0));
        send_cmd(make_cmd(OP_READ, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
        send_cmd(make_cmd(OP_INIT, 32'd0, 32'hFFFF_FFFF));
        send_cmd(make_cmd(OP_STEP, 32'd0, 32'd0));
        send_cmd(make_cmd(OP_INJECT, 32'd0, 32'd0));
        send_cmd(make_cmd(OP_STEP, 32'd0, 32'd0));
        send_cmd(make_cmd(OP_INJECT, 32'd0, 32'hFFFF_FFFF));
        send_cmd(make_cmd(OP_STEP, 32'd0, 32'd0));
        send_cmd(make_cmd(OP_INIT, 32'hFFFF_FFFF, 32'd0));
        send_cmd(make_cmd(OP_INJECT, 32'd0, 32'd1));
        send_cmd(make_cmd(OP_STEP, 32'd0, 32'd0));
        send_cmd(make_cmd(OP_READ, 32'd0, 32'd0));
        send_cmd(make_cmd(OP_INIT, 32'd1, 32'd0));
        send_cmd(make_cmd(OP_INIT, C_ZERO_SEED, 32'd0));
        send_cmd(make_cmd(OP_INJECT, 32'd0, 32'h8000_0000));
        for (int i = 0; i < 5; i++) begin
            send_cmd(make_cmd(OP_STEP, 32'd0, 32'd0));
        end
        send_cmd(make_cmd(OP_READ, 32'd0, 32'd0));

        drain_results();

        // Random: mostly steps so that levels build up between inits.
        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            if (i == RANDOM_ITEMS / 2) begin
                drain_results();
            end
            if (i == RANDOM_ITEMS - TAIL_ITEMS) begin
                quiet_tail = 1'b1;
            end
            cmd.init_seed = $urandom();
            cmd.salt = $urandom();
            pick = $urandom_range(0, 99);
            if (pick < 8) begin
                cmd.operation = OP_INIT;
                if ($urandom_range(0, 9) == 0) begin
                    cmd.init_seed = 32'd0;
                end
            end else if (pick < 25) begin
                cmd.operation = OP_INJECT;
            end else if (pick < 82) begin
                cmd.operation = OP_STEP;
            end else begin
                cmd.operation = OP_READ;
            end
            send_cmd(cmd);
        end

        drain_results();
        repeat (C_LANES + 10) @(posedge i_clk);

        if (bank.mismatch_count == 0) begin
            $display("tb_top: clean");
        end else begin
            $display("tb_top: errors");
        end
        $finish;
    end

endmodule

@@ files.f @@
hdl/dlib_pkg.sv
hdl/dlib_if.sv
hdl/dlib_ctrl.sv
hdl/dlib_datapath.sv
hdl/dithered_leaky_integrator_bank.sv
tb/sv/tb_top.sv
